### hdl/histogram_inverse_cdf_sampler_macros.svh
// Assertion macros used by the sampler's RTL.
`ifndef HISTOGRAM_INVERSE_CDF_SAMPLER_MACROS_SVH
`define HISTOGRAM_INVERSE_CDF_SAMPLER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define HICS_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sampler check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define HICS_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sampler check failed");

`endif

### hdl/hics_pkg.sv
// Shared codes and field widths of the histogram inverse-CDF sampler.
`default_nettype none

package hics_pkg;

	localparam int BIN_W = 11;
	localparam int X_W   = 32;
	localparam int C_W   = 33;
	localparam int U_W   = 32;
	localparam int NB_W  = 11;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	localparam logic ST_OK    = 1'b0;
	localparam logic ST_EMPTY = 1'b1;

	localparam logic [1:0] CFG_NUM_BINS  = 2'd0;
	localparam logic [1:0] CFG_X_LOW     = 2'd1;
	localparam logic [1:0] CFG_BIN_WIDTH = 2'd2;

	localparam logic [NB_W-1:0] RST_NUM_BINS  = 11'd1024;
	localparam logic [X_W-1:0]  RST_X_LOW     = 32'd0;
	localparam logic [31:0]     RST_BIN_WIDTH = 32'd65536;

endpackage

`default_nettype wire

### hdl/histogram_inverse_cdf_sampler.sv
// Throughput: one transaction per cycle unless the output stalls; the search keeps one
// table copy per level and the 64 one-bit stages of the restoring divider set the depth.
// A stalled output holds the whole pipeline; loads give no result.
// Reset clears the valid bits and loads the register defaults; table contents stay
// undefined until loaded, so no clearing pass is run.
`default_nettype none
`include "histogram_inverse_cdf_sampler_macros.svh"

module histogram_inverse_cdf_sampler
	import hics_pkg::*;
#(
	parameter int MAX_BINS = 1024
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [1:0]              cfg_index,
	input  wire logic [31:0]             cfg_data,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic                    cmd,
	input  wire logic [NB_W-1:0]         entry_index,
	input  wire logic [C_W-1:0]          entry_value,
	input  wire logic [U_W-1:0]          random_value,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic                         status,
	output logic signed [BIN_W-1:0]      bin_index,
	output logic signed [X_W-1:0]        sample_x
);

	localparam int AW    = $clog2(MAX_BINS + 1);
	localparam int BW    = AW + 1;
	localparam int DEPTH = MAX_BINS + 1;
	localparam int L     = AW;
	localparam int BSW   = AW + 34;
	localparam int SW    = ((BSW > 52) ? BSW : 52) + 1;
	localparam int QW    = 64;

	typedef struct packed {
		logic          vld;
		logic          smp;
		logic          ldok;
		logic [AW-1:0] addr;
		logic [C_W-1:0] val;
		logic [U_W-1:0] u;
		logic [BW-1:0] lo_b;
		logic [BW-1:0] hi_b;
		logic          found;
		logic [AW-1:0] res;
		logic [AW-1:0] mid;
		logic          empty;
	} srch_t;

	typedef struct packed {
		logic           vld;
		logic           empty;
		logic           neg;
		logic [AW-1:0]  binc;
		logic [U_W-1:0] u;
	} tap_t;

	typedef struct packed {
		logic           vld;
		logic           empty;
		logic [AW-1:0]  binc;
		logic           doint;
		logic [31:0]    num;
		logic [C_W-1:0] den;
		logic [AW+31:0] bwp;
	} mul_t;

	typedef struct packed {
		logic                  vld;
		logic                  empty;
		logic [AW-1:0]         binc;
		logic                  doint;
		logic [C_W-1:0]        den;
		logic signed [BSW-1:0] base;
		logic [C_W-1:0]        rem;
		logic [QW-1:0]         dvd;
		logic [QW-1:0]         q;
	} div_t;

	typedef struct packed {
		logic                  vld;
		logic                  empty;
		logic [AW-1:0]         binc;
		logic signed [BSW-1:0] base;
		logic [50:0]           term;
	} fin_t;

	function automatic srch_t upd(input srch_t s, input logic [C_W-1:0] c);
		srch_t       r;
		logic [BW:0] sum;
		r = s;
		if (!s.found && ((s.hi_b - s.lo_b) > BW'(1))) begin
			if ({1'b0, s.u} == c) begin
				r.found = 1'b1;
				r.res   = s.mid - AW'(1);
			end else if ({1'b0, s.u} < c) begin
				r.hi_b = {1'b0, s.mid};
			end else begin
				r.lo_b = {1'b0, s.mid};
			end
		end
		sum   = {1'b0, r.hi_b} + {1'b0, r.lo_b};
		r.mid = sum[AW:1];
		return r;
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic [AW-1:0] mid);
		return (mid == '0) ? '0 : mid - AW'(1);
	endfunction

	function automatic div_t dstep(input div_t d);
		div_t           r;
		logic [C_W:0]   r2;
		logic           ge;
		r     = d;
		r2    = {d.rem, d.dvd[QW-1]};
		ge    = (r2 >= {1'b0, d.den});
		r.rem = ge ? C_W'(r2 - {1'b0, d.den}) : r2[C_W-1:0];
		r.dvd = {d.dvd[QW-2:0], 1'b0};
		r.q   = {d.q[QW-2:0], ge};
		return r;
	endfunction

	logic            adv;
	logic            accept;
	logic [NB_W-1:0] num_bins_q;
	logic [31:0]     x_low_q;
	logic [31:0]     bin_width_q;
	logic [AW-1:0]   n_eff;
	logic            in_ldok;

	srch_t          ent;
	srch_t          srch_s [1:L];
	srch_t          nxt    [2:L];
	srch_t          fs;
	logic [C_W-1:0] cdat   [0:L-1];
	logic           lv_we  [0:L-1];
	logic [AW-1:0]  lv_wa  [0:L-1];
	logic [C_W-1:0] lv_wd  [0:L-1];
	logic [AW-1:0]  lv_ra  [0:L-1];
	logic [C_W-1:0] cn_s1;

	logic [BW-1:0]  fbin;
	tap_t           tap_n, tap_s;
	logic [C_W-1:0] tlo_s, thi_s;
	logic           tab_we;
	mul_t           mul_n, mul_s;
	div_t           div_s [0:QW];
	div_t           div_s_n;
	fin_t           fin_n, fin_s;

	logic                    out_valid_q;
	logic                    status_q;
	logic signed [BIN_W-1:0] bin_q;
	logic signed [X_W-1:0]   x_q;
	logic signed [SW-1:0]    xsum;

	logic [C_W-1:0] ntab [0:DEPTH-1];
	logic [C_W-1:0] ttab [0:DEPTH-1];

	// The whole pipeline moves together; it halts only behind a held result.
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv;
	assign accept   = in_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_bins_q  <= RST_NUM_BINS;
			x_low_q     <= RST_X_LOW;
			bin_width_q <= RST_BIN_WIDTH;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NUM_BINS:  num_bins_q  <= cfg_data[NB_W-1:0];
				CFG_X_LOW:     x_low_q     <= cfg_data;
				CFG_BIN_WIDTH: bin_width_q <= cfg_data;
				default:       ;
			endcase
		end
	end

	always_comb begin
		if (num_bins_q == '0) begin
			n_eff = AW'(1);
		end else if (32'(num_bins_q) > 32'(MAX_BINS)) begin
			n_eff = AW'(MAX_BINS);
		end else begin
			n_eff = AW'(num_bins_q);
		end
	end

	assign in_ldok = (32'(entry_index) <= 32'(MAX_BINS));

	always_comb begin
		logic [BW:0] sum;
		ent       = '0;
		ent.vld   = in_valid;
		ent.smp   = (cmd == CMD_SAMPLE);
		ent.ldok  = in_ldok;
		ent.addr  = AW'(entry_index);
		ent.val   = entry_value;
		ent.u     = random_value;
		ent.lo_b  = '0;
		ent.hi_b  = {1'b0, n_eff} + BW'(1);
		sum       = {1'b0, ent.hi_b};
		ent.mid   = sum[AW:1];
	end

	// Search level k reads its own table copy; a load writes copy k as it passes level k,
	// so every sample sees exactly the loads that came before it.
	always_comb begin
		for (int j = 1; j < L; j++) begin
			nxt[j+1] = upd(srch_s[j], cdat[j-1]);
			if (j == 1) begin
				nxt[j+1].empty = (cn_s1 == '0);
			end
		end
		lv_we[0] = in_valid && (cmd == CMD_LOAD) && in_ldok;
		lv_wa[0] = AW'(entry_index);
		lv_wd[0] = entry_value;
		lv_ra[0] = addr_of(ent.mid);
		for (int k = 1; k < L; k++) begin
			lv_we[k] = srch_s[k].vld && !srch_s[k].smp && srch_s[k].ldok;
			lv_wa[k] = srch_s[k].addr;
			lv_wd[k] = srch_s[k].val;
			lv_ra[k] = addr_of(nxt[k+1].mid);
		end
	end

	for (genvar k = 0; k < L; k++) begin : g_lvl
		logic [C_W-1:0] mem [0:DEPTH-1];
		always_ff @(posedge clk) begin
			if (adv) begin
				if (lv_we[k]) begin
					mem[lv_wa[k]] <= lv_wd[k];
				end
				cdat[k] <= mem[lv_ra[k]];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (lv_we[0]) begin
				ntab[lv_wa[0]] <= lv_wd[0];
			end
			cn_s1 <= ntab[n_eff];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 1; j <= L; j++) begin
				srch_s[j].vld <= 1'b0;
			end
		end else if (adv) begin
			srch_s[1] <= ent;
			for (int j = 2; j <= L; j++) begin
				srch_s[j] <= nxt[j];
			end
		end
	end

	// End of the search: the bin below the first entry is folded to bin 0.
	always_comb begin
		fs           = upd(srch_s[L], cdat[L-1]);
		fbin         = fs.found ? {1'b0, fs.res} : fs.lo_b - BW'(1);
		tap_n.vld    = srch_s[L].vld && srch_s[L].smp;
		tap_n.empty  = srch_s[L].empty;
		tap_n.neg    = fbin[BW-1];
		tap_n.binc   = fbin[BW-1] ? '0 : fbin[AW-1:0];
		tap_n.u      = srch_s[L].u;
		tab_we       = srch_s[L].vld && !srch_s[L].smp && srch_s[L].ldok;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (tab_we) begin
				ttab[srch_s[L].addr] <= srch_s[L].val;
			end
			tlo_s <= ttab[tap_n.binc];
			thi_s <= ttab[tap_n.binc + AW'(1)];
		end
	end

	always_comb begin
		mul_n.vld   = tap_s.vld;
		mul_n.empty = tap_s.empty;
		mul_n.binc  = tap_s.binc;
		mul_n.doint = !tap_s.neg && ({1'b0, tap_s.u} > tlo_s) && (thi_s > tlo_s);
		mul_n.num   = tap_s.u - tlo_s[31:0];
		mul_n.den   = thi_s - tlo_s;
		mul_n.bwp   = (AW+32)'(tap_s.binc) * (AW+32)'(bin_width_q);
	end

	always_comb begin
		div_t d;
		d       = '0;
		d.vld   = mul_s.vld;
		d.empty = mul_s.empty;
		d.binc  = mul_s.binc;
		d.doint = mul_s.doint;
		d.den   = mul_s.den;
		d.base  = BSW'($signed(x_low_q)) + $signed({2'b00, mul_s.bwp});
		d.rem   = '0;
		d.dvd   = QW'(bin_width_q) * QW'(mul_s.num);
		d.q     = '0;
		div_s_n = d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_s.vld <= 1'b0;
			mul_s.vld <= 1'b0;
			for (int i = 0; i <= QW; i++) begin
				div_s[i].vld <= 1'b0;
			end
			fin_s.vld <= 1'b0;
		end else if (adv) begin
			tap_s    <= tap_n;
			mul_s    <= mul_n;
			div_s[0] <= div_s_n;
			for (int i = 0; i < QW; i++) begin
				div_s[i+1] <= dstep(div_s[i]);
			end
			fin_s <= fin_n;
		end
	end

	// The quotient is capped at 2^50 before the sum.
	always_comb begin
		logic [QW-1:0] q;
		q           = div_s[QW].q;
		fin_n.vld   = div_s[QW].vld;
		fin_n.empty = div_s[QW].empty;
		fin_n.binc  = div_s[QW].binc;
		fin_n.base  = div_s[QW].base;
		if (!div_s[QW].doint) begin
			fin_n.term = '0;
		end else if ((q[QW-1:51] != '0) || (q[50] && (q[49:0] != '0))) begin
			fin_n.term = {1'b1, 50'd0};
		end else begin
			fin_n.term = q[50:0];
		end
	end

	assign xsum = SW'(fin_s.base) + $signed({{(SW-51){1'b0}}, fin_s.term});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= fin_s.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && fin_s.vld) begin
			if (fin_s.empty) begin
				status_q <= ST_EMPTY;
				bin_q    <= '1;
				x_q      <= '0;
			end else begin
				status_q <= ST_OK;
				bin_q    <= BIN_W'(fin_s.binc);
				if (xsum[SW-1:31] == '0 || xsum[SW-1:31] == '1) begin
					x_q <= xsum[31:0];
				end else begin
					x_q <= xsum[SW-1] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign bin_index = bin_q;
	assign sample_x  = x_q;

	`HICS_ASSERT_IMPL(a_empty_shape, out_valid && (status == ST_EMPTY), (bin_index == '1) && (sample_x == '0))
	`HICS_ASSERT_IMPL(a_hold_input, out_valid && out_stall, in_stall)
	`HICS_ASSERT_NEXT(a_fin_delivers, adv && fin_s.vld, out_valid)

endmodule

`default_nettype wire

### tb/sv/tb_histogram_inverse_cdf_sampler.sv
// Self-checking testbench for the histogram inverse-CDF sampler: loads, samples and register sweeps.
`timescale 1ns / 100ps

module tb_histogram_inverse_cdf_sampler;
	import hics_pkg::*;

	localparam int TABLE_TOP   = 1024;
	localparam int DRAIN_WAIT  = 120;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TARGET      = 2000;
	localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

	typedef struct packed {
		logic        op;
		logic [10:0] idx;
		logic [32:0] val;
		logic [31:0] u;
	} cdf_req_t;

	typedef struct packed {
		logic        st;
		logic [10:0] bin;
		logic [31:0] x;
	} draw_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = CFG_NUM_BINS;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic cmd = CMD_LOAD;
	logic [NB_W-1:0] entry_index = '0;
	logic [C_W-1:0] entry_value = '0;
	logic [U_W-1:0] random_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic status;
	logic signed [BIN_W-1:0] bin_index;
	logic signed [X_W-1:0] sample_x;

	histogram_inverse_cdf_sampler i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
		.entry_index(entry_index), .entry_value(entry_value), .random_value(random_value),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.bin_index(bin_index), .sample_x(sample_x)
	);

	// Predictor state, updated at acceptance.
	logic [32:0] cdf_model [0:TABLE_TOP];
	logic [10:0] nb_model = RST_NUM_BINS;
	logic [31:0] xlow_model = RST_X_LOW;
	logic [31:0] width_model = RST_BIN_WIDTH;

	// Generator view of the table, updated when an item is queued.
	logic [32:0] cdf_gen [0:TABLE_TOP];
	bit cdf_loaded [0:TABLE_TOP];

	cdf_req_t pending_q[$];
	draw_t expected_draws[$];
	int errors = 0;
	int cycles = 0;
	int queued = 0;
	bit hold_off = 1'b0;

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// No random idling on either side inside this window.
	function automatic bit idle_now();
		if (cycles >= 4000 && cycles < 7000)
			return 1'b0;
		return $urandom_range(99) < 9;
	endfunction

	task automatic predict_draw(input logic [31:0] u);
		int n, lo_b, hi_b, mid, bin;
		bit found;
		logic [63:0] num, den, term;
		longint x;
		draw_t d;
		n = nb_model;
		if (n == 0) n = 1;
		if (n > TABLE_TOP) n = TABLE_TOP;
		if (cdf_model[n] == 0) begin
			d.st = ST_EMPTY;
			d.bin = 11'h7FF;
			d.x = '0;
			expected_draws.push_back(d);
			return;
		end
		lo_b = 0;
		hi_b = n + 1;
		found = 1'b0;
		bin = 0;
		while (!found && hi_b - lo_b > 1) begin
			mid = (hi_b + lo_b) / 2;
			if ({1'b0, u} == cdf_model[mid-1]) begin
				bin = mid - 1;
				found = 1'b1;
			end else if ({1'b0, u} < cdf_model[mid-1]) hi_b = mid;
			else lo_b = mid;
		end
		if (!found) bin = lo_b - 1;
		term = '0;
		// A value below the first entry lands on bin 0 with no interpolation.
		if (bin < 0) begin
			bin = 0;
		end else if ({1'b0, u} > cdf_model[bin] && cdf_model[bin+1] > cdf_model[bin]) begin
			num = 64'(u) - 64'(cdf_model[bin]);
			den = 64'(cdf_model[bin+1]) - 64'(cdf_model[bin]);
			term = (64'(width_model) * num) / den;
		end
		if (term > (64'd1 << 50)) term = 64'd1 << 50;
		x = longint'($signed(xlow_model)) + longint'(bin) * longint'({32'd0, width_model})
			+ longint'(term);
		if (x > 64'sd2147483647) x = 64'sd2147483647;
		if (x < -64'sd2147483648) x = -64'sd2147483648;
		d.st = ST_OK;
		d.bin = 11'(bin);
		d.x = 32'(x);
		expected_draws.push_back(d);
	endtask

	// Driver.
	always @(posedge clk or negedge arst_n) begin
		cdf_req_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				if (cmd == CMD_LOAD) begin
					if (entry_index <= TABLE_TOP) cdf_model[entry_index] = entry_value;
				end else begin
					predict_draw(random_value);
				end
			end
			if (!in_valid || !in_stall) begin
				if (pending_q.size() > 0 && !idle_now()) begin
					r = pending_q.pop_front();
					cmd <= r.op;
					entry_index <= r.idx;
					entry_value <= r.val;
					random_value <= r.u;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor.
	always @(posedge clk or negedge arst_n) begin
		draw_t d;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_draws.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("Unexpected result: status %0b bin %0d x %h",
							status, bin_index, sample_x);
				end else begin
					d = expected_draws.pop_front();
					if (status !== d.st || bin_index !== d.bin || sample_x !== d.x) begin
						errors++;
						if (errors <= 10)
							$display("Mismatch: expected st %0b bin %h x %h, got st %0b bin %h x %h",
								d.st, d.bin, d.x, status, bin_index, sample_x);
					end
				end
			end
			out_stall <= hold_off || idle_now();
		end
	end

	// The receiver holds off once the sender has a backlog, so the pipeline fills.
	initial begin
		wait (pending_q.size() > 300);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (400) @(posedge clk);
		hold_off = 1'b0;
	end

	task automatic push_load(input int idx, input logic [32:0] val);
		cdf_req_t r;
		r.op = CMD_LOAD;
		r.idx = 11'(idx);
		r.val = val;
		r.u = $urandom;
		pending_q.push_back(r);
		if (idx <= TABLE_TOP) begin
			cdf_gen[idx] = val;
			cdf_loaded[idx] = 1'b1;
			queued++;
		end
	endtask

	task automatic push_draw(input logic [31:0] u);
		cdf_req_t r;
		r.op = CMD_SAMPLE;
		r.idx = 11'($urandom);
		r.val = {1'b0, $urandom};
		r.u = u;
		pending_q.push_back(r);
		queued++;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_NUM_BINS:  nb_model = val[10:0];
			CFG_X_LOW:     xlow_model = val;
			CFG_BIN_WIDTH: width_model = val;
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_q.size() > 0 || in_valid || expected_draws.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	function automatic int used_bins(input logic [10:0] nb);
		if (nb == 0) return 1;
		if (nb > TABLE_TOP) return TABLE_TOP;
		return nb;
	endfunction

	// Loads entries 0..n; mostly nondecreasing with flat steps, sometimes scrambled.
	task automatic fill_table(input int n, input bit scrambled);
		logic [63:0] cur, span;
		cur = $urandom_range(3) == 0 ? 64'd0 : 64'($urandom_range(1000));
		span = (64'd1 << 33) / (n + 1);
		for (int i = 0; i <= n; i++) begin
			if (scrambled) begin
				push_load(i, 33'({$urandom, $urandom} % (64'(ONE_Q32) + 1)));
			end else begin
				if ($urandom_range(4) != 0) cur = cur + ({$urandom, $urandom} % (span + 1));
				if (cur > 64'(ONE_Q32) || (i == n && $urandom_range(1) == 0)) cur = ONE_Q32;
				push_load(i, 33'(cur));
			end
		end
	endtask

	function automatic logic [31:0] pick_u(input int n);
		int k;
		k = $urandom_range(99);
		if (k < 65) return $urandom;
		if (k < 80) return cdf_gen[$urandom_range(n)][31:0];
		if (k < 88) return cdf_gen[$urandom_range(n)][31:0] + 32'd1;
		if (k < 94) return '0;
		return '1;
	endfunction

	initial begin
		int n, k, phase;
		logic [31:0] nb_val, xl_val, bw_val;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: four bins with a flat step and a full top entry.
		write_reg(CFG_NUM_BINS, 32'd4);
		write_reg(CFG_X_LOW, 32'd0);
		write_reg(CFG_BIN_WIDTH, 32'd65536);
		push_load(0, 33'd1000);
		push_load(1, 33'd1000);
		push_load(2, 33'h0_8000_0000);
		push_load(3, 33'h0_8000_0005);
		push_load(4, ONE_Q32);
		push_load(2047, 33'd0);
		push_draw(32'd0);
		push_draw(32'd999);
		push_draw(32'd1000);
		push_draw(32'd1500);
		push_draw(32'h8000_0000);
		push_draw(32'h8000_0003);
		push_draw(32'hFFFF_FFFF);
		push_load(4, 33'd0);
		push_draw(32'h1234_5678);
		push_load(3, 33'd10);
		push_load(4, 33'd5);
		push_draw(32'd7);
		push_draw(32'hFFFF_FFFF);
		push_load(4, ONE_Q32);
		push_draw(32'h7FFF_FFFF);
		drain();

		phase = 0;
		while (queued < TARGET + 25) begin
			case (phase % 8)
				2:       nb_val = 32'd2047;
				5:       nb_val = 32'd0;
				6:       nb_val = 32'd1;
				default: nb_val = $urandom_range(1, 40);
			endcase
			if (phase == 9) nb_val = 32'd1024;
			k = $urandom_range(9);
			xl_val = k == 0 ? 32'h8000_0000 : k == 1 ? 32'h7FFF_FFFF : k < 4 ? 32'd0 : $urandom;
			k = $urandom_range(9);
			bw_val = k == 0 ? 32'd0 : k == 1 ? 32'hFFFF_FFFF : k < 4 ? 32'd65536
				: $urandom_range(1, 1 << 20);
			write_reg(CFG_NUM_BINS, nb_val);
			write_reg(CFG_X_LOW, xl_val);
			write_reg(CFG_BIN_WIDTH, bw_val);
			n = used_bins(nb_val[10:0]);
			if (n > 100) begin
				for (int i = 0; i <= n; i++)
					if (!cdf_loaded[i]) push_load(i, 33'(i) << 22);
			end else begin
				fill_table(n, $urandom_range(5) == 0);
			end
			repeat ($urandom_range(60, 200)) begin
				k = $urandom_range(99);
				if (k < 78) push_draw(pick_u(n));
				else if (k < 90) push_load($urandom_range(n), 33'({$urandom, $urandom}
					% (64'(ONE_Q32) + 1)));
				else if (k < 94) push_load($urandom_range(TABLE_TOP + 1, 2047), {1'b1, $urandom});
				else if (k < 97) push_load(n, $urandom_range(1) ? 33'd0 : ONE_Q32);
				else fill_table(n, 1'b0);
			end
			drain();
			phase++;
		end

		drain();
		if (errors == 0 && expected_draws.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
